### rtl/psd_pkg.sv
// Package for the position settle detector: field widths, status and
// request codes, register indexes, register reset values and the request item.
// No dependencies.
package psd_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned PosW    = 24;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  // Result codes
  typedef enum logic [1:0] {
    StRunning = 2'd0,
    StSuccess = 2'd1,
    StFailure = 2'd2
  } status_e;

  // Request codes
  localparam logic ReqStart = 1'b0;
  localparam logic ReqPoll  = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMoveThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSettleTime    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout       = 2'd2;

  // Register reset values
  localparam logic [ThrW-1:0]  MoveThresholdRst = 16'd50;
  localparam logic [TimeW-1:0] SettleTimeRst    = 32'd2000;
  localparam logic [TimeW-1:0] TimeoutRst       = 32'd30000;

  typedef struct packed {
    logic                   req_type;
    logic [TimeW-1:0]       now_ms;
    logic                   pos_present;
    logic                   pos_valid;
    logic signed [PosW-1:0] pos_x_mm;
    logic signed [PosW-1:0] pos_y_mm;
  } in_item_t;

endpackage

### rtl/psd_cfg_if.sv
// Configuration write channel of the position settle detector.
// Depends on psd_pkg.
interface psd_cfg_if import psd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/psd_in_if.sv
// Request channel of the position settle detector: start or poll items.
// Depends on psd_pkg.
interface psd_in_if import psd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [TimeW-1:0]       now_ms;
  logic                   pos_present;
  logic                   pos_valid;
  logic signed [PosW-1:0] pos_x_mm;
  logic signed [PosW-1:0] pos_y_mm;

  modport source (output valid, output req_type, output now_ms, output pos_present,
                  output pos_valid, output pos_x_mm, output pos_y_mm, input ready);
  modport sink   (input valid, input req_type, input now_ms, input pos_present,
                  input pos_valid, input pos_x_mm, input pos_y_mm, output ready);
endinterface

### rtl/psd_out_if.sv
// Result channel of the position settle detector: one status per request.
// Depends on psd_pkg.
interface psd_out_if import psd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

### rtl/position_settle_detector.sv
// Position settle detector top level: request register, combinational
// evaluation against the anchor state, and result register.
// Depends on psd_pkg, psd_cfg_if, psd_in_if and psd_out_if.
//
// Usage:
//   cfg_i : register writes (move threshold, settle time, timeout), always
//           ready; an index beyond the list is dropped. Write only while idle.
//   in_i  : start (req_type 0) or poll (req_type 1) requests with a
//           millisecond timestamp and a planar position.
//   out_o : one status per request, in order: 0 running, 1 success,
//           2 failure.
// The result is registered. Throughput is one request per cycle while the
// receiver takes results: the request register and the result register form a
// two-stage pipeline, and the anchor and time stamps are updated as the request
// moves into the result register, so the next request already sees them. The
// evaluation is two 25x25 squarings, a 16x16 threshold squaring, a sum and a
// compare, all in that one stage. When the receiver stalls, the result holds
// and the request register still takes one further request; then in_i.ready
// drops. Reset clears both stages, the stamps and the anchor, and loads the
// register reset values.
module position_settle_detector import psd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  psd_cfg_if.sink  cfg_i,
  psd_in_if.sink   in_i,
  psd_out_if.source out_o
);

  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned SqW   = 2 * DiffW;

  // Configuration
  logic [ThrW-1:0]  thr_q;
  logic [TimeW-1:0] settle_q;
  logic [TimeW-1:0] timeout_q;

  // Request stage
  in_item_t item_q;
  logic     item_vld_q;
  logic     in_ready;
  logic     advance;

  // Tracking state
  logic [TimeW-1:0]       start_stamp_q;
  logic [TimeW-1:0]       move_stamp_q;
  logic signed [PosW-1:0] anchor_x_q;
  logic signed [PosW-1:0] anchor_y_q;
  logic                   anchor_set_q;

  // Result stage
  logic    out_vld_q;
  status_e status_q;
  status_e status_d;

  // Evaluation
  logic [TimeW-1:0]        elapsed;
  logic [TimeW-1:0]        still;
  logic                    timed_out;
  logic signed [DiffW-1:0] dx;
  logic signed [DiffW-1:0] dy;
  logic [DiffW-1:0]        dx_mag;
  logic [DiffW-1:0]        dy_mag;
  logic [SqW-1:0]          dist_sq;
  logic [SqW-1:0]          thr_sq;
  logic                    moved;
  logic                    sample_ok;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= MoveThresholdRst;
      settle_q  <= SettleTimeRst;
      timeout_q <= TimeoutRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgMoveThreshold: thr_q     <= cfg_i.data[ThrW-1:0];
        CfgSettleTime:    settle_q  <= cfg_i.data[TimeW-1:0];
        CfgTimeout:       timeout_q <= cfg_i.data[TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = item_vld_q && (!out_vld_q || out_o.ready);
  assign in_ready   = !item_vld_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.req_type    <= in_i.req_type;
      item_q.now_ms      <= in_i.now_ms;
      item_q.pos_present <= in_i.pos_present;
      item_q.pos_valid   <= in_i.pos_valid;
      item_q.pos_x_mm    <= in_i.pos_x_mm;
      item_q.pos_y_mm    <= in_i.pos_y_mm;
    end
  end

  always_comb begin
    elapsed   = item_q.now_ms - start_stamp_q;
    timed_out = elapsed > timeout_q;

    dx     = {item_q.pos_x_mm[PosW-1], item_q.pos_x_mm} - {anchor_x_q[PosW-1], anchor_x_q};
    dy     = {item_q.pos_y_mm[PosW-1], item_q.pos_y_mm} - {anchor_y_q[PosW-1], anchor_y_q};
    dx_mag = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
    dy_mag = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

    dist_sq = SqW'(SqW'(dx_mag) * SqW'(dx_mag)) + SqW'(SqW'(dy_mag) * SqW'(dy_mag));
    thr_sq  = SqW'(SqW'(thr_q) * SqW'(thr_q));
    moved   = anchor_set_q && (dist_sq > thr_sq);

    // a poll that reaches the anchor logic
    sample_ok = (item_q.req_type == ReqPoll) && item_q.pos_present && !timed_out
                && item_q.pos_valid;

    // a move restamps to now, so the still time is zero
    still = moved ? '0 : item_q.now_ms - move_stamp_q;

    priority if (item_q.req_type == ReqStart) begin
      status_d = StRunning;
    end else if (!item_q.pos_present) begin
      status_d = StFailure;
    end else if (timed_out) begin
      status_d = StSuccess;
    end else if (!item_q.pos_valid) begin
      status_d = StRunning;
    end else if (still >= settle_q) begin
      status_d = StSuccess;
    end else begin
      status_d = StRunning;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_stamp_q <= '0;
      move_stamp_q  <= '0;
      anchor_x_q    <= '0;
      anchor_y_q    <= '0;
      anchor_set_q  <= 1'b0;
    end else if (advance) begin
      if (item_q.req_type == ReqStart) begin
        start_stamp_q <= item_q.now_ms;
        move_stamp_q  <= item_q.now_ms;
        anchor_set_q  <= 1'b0;
      end else if (sample_ok && (!anchor_set_q || moved)) begin
        anchor_x_q   <= item_q.pos_x_mm;
        anchor_y_q   <= item_q.pos_y_mm;
        anchor_set_q <= 1'b1;
        if (moved) begin
          move_stamp_q <= item_q.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      status_q  <= StRunning;
    end else if (advance) begin
      out_vld_q <= 1'b1;
      status_q  <= status_d;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid  = out_vld_q;
  assign out_o.status = status_q;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (item_vld_q && out_vld_q && !out_o.ready))
    else $error("request stage stalled without a blocked result");

  a_start_gives_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.req_type == ReqStart) |=> (out_vld_q && status_q == StRunning))
    else $error("start request did not report running");

  a_start_clears_anchor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.req_type == ReqStart) |=> !anchor_set_q)
    else $error("start request left the anchor set");

  a_absent_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_q.req_type == ReqPoll && !item_q.pos_present)
    |=> (status_q == StFailure && $stable(anchor_set_q)))
    else $error("poll without position did not fail cleanly");

  a_move_restamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && sample_ok && moved) |=> (move_stamp_q == $past(item_q.now_ms)))
    else $error("movement did not restamp the move time");
`endif

endmodule
